FILE: src/lmed_pkg.sv
`timescale 1ns / 1ps

package lmed_pkg;

    // matrix geometry and pwm depth
    localparam int ROWS       = 8;
    localparam int COLS       = 8;
    localparam int PWM_LEVELS = 20;
    localparam int TOTAL      = ROWS * COLS;

    localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_IDX_W = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int SLOT_W    = $clog2(ROWS + 1);
    localparam int SUB_W     = $clog2(PWM_LEVELS + 1);
    localparam int LIT_W     = $clog2(TOTAL + 1);

    // divider: 16-bit elapsed times total (<= 8 bits), or flash elapsed time (25 bits)
    localparam int DVD_W = 25;
    localparam int DVS_W = 16;
    localparam int CNT_W = $clog2(DVD_W);
    localparam int DUTY_W = 13;

    // stream and config widths
    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // config register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_BRIGHTNESS = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SCAN_DUR   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FLASH_PER  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FLASH_REP  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SPECIAL_EN = 3'd4;

    // register reset values
    localparam logic [6:0]  RST_BRIGHTNESS = 7'd100;
    localparam logic [15:0] RST_SCAN_DUR   = 16'd2000;
    localparam logic [15:0] RST_FLASH_PER  = 16'd500;
    localparam logic [7:0]  RST_FLASH_REP  = 8'd3;

    localparam logic [7:0] SPECIAL_MASK = 8'h01;

    typedef enum logic [2:0] {
        CMD_TICK        = 3'd0,
        CMD_START_SCAN  = 3'd1,
        CMD_START_FLASH = 3'd2,
        CMD_STOP        = 3'd3,
        CMD_SET_PIXEL   = 3'd4,
        CMD_CLR_PIXEL   = 3'd5,
        CMD_CLEAR_ALL   = 3'd6,
        CMD_REFRESH     = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_SCAN  = 2'd1,
        MODE_FLASH = 2'd2
    } t_mode;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_EXEC = 7'b0000010,
        ST_PREP = 7'b0000100,
        ST_CHK  = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_FILL = 7'b0100000,
        ST_FIN  = 7'b1000000
    } t_state;

endpackage

FILE: src/led_matrix_effect_driver.sv
`timescale 1ns / 1ps

// LED matrix effect driver. Holds a ROWS x COLS pixel bitmap and runs a scan
// fill or flash effect on it, advanced by tick items (one per millisecond),
// and answers refresh-slot items with the row and column mask to drive. Every
// input item yields exactly one output item carrying the drive fields and the
// effect mode left after the item. One item is handled at a time: s_axis_tready
// is high only while the sequencer is idle. Refresh, pixel edits, start, stop
// and clear commands and ticks with no effect running pass through an execute
// state and then load their result into the output register. A tick during a
// running effect first spends one shared 16x8 multiplier step and a compare
// step. A tick that ends the effect then loads its result; the last scan
// millisecond skips the divider and takes a bitmap load step before loading;
// any other tick runs a one-bit-per-cycle restoring divider (scan fill count or
// flash phase) and a bitmap load step before loading. A stalled output only
// delays the final load by the stalled cycles, it never drops an item.
// Configuration writes are registered and are expected while idle.
module led_matrix_effect_driver
    import lmed_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // config write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,

    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [3:0] pixel_row, [7:4] pixel_col
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [2:0] command
    input  logic [IN_USER_W-1:0]  s_axis_tuser,

    // output items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [3:0] out_row, [11:4] drive_cols, [13:12] effect_mode, [15:14] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [0] drive_valid
    output logic                  m_axis_tuser
);

    // config registers
    logic [6:0]  r_bright;
    logic [15:0] r_scan_dur;
    logic [15:0] r_flash_per;
    logic [7:0]  r_flash_rep;
    logic        r_special_en;

    // block state
    t_state              r_state, n_state;
    t_mode               r_mode;
    logic [COLS-1:0]     r_pix [ROWS];
    logic [31:0]         r_elapsed;
    logic [SUB_W-1:0]    r_sub;
    logic [SLOT_W-1:0]   r_slot;

    // latched item
    logic [2:0]          r_cmd;
    logic [3:0]          r_row;
    logic [3:0]          r_col;

    // drive fields of the pending result
    logic                r_drv_valid;
    logic [3:0]          r_drv_row;
    logic [7:0]          r_drv_cols;

    // shared multiplier and divider
    logic [DVD_W-1:0]    r_prod;
    logic [DVD_W-1:0]    r_dvd;
    logic [DVS_W-1:0]    r_dvs;
    logic [DVS_W-1:0]    r_rem;
    logic [CNT_W-1:0]    r_cnt;

    // output register
    logic                    r_out_valid;
    logic [OUT_DATA_W-1:0]   r_out_data;
    logic                    r_out_user;

    logic                    w_accept;
    logic                    w_out_free;
    logic [15:0]             w_mul_a;
    logic [7:0]              w_mul_b;
    logic [23:0]             w_mul_p;
    logic [DVS_W:0]          w_rem_sh;
    logic                    w_sub_ok;
    logic [DVS_W:0]          w_rem_diff;
    logic [ROW_IDX_W-1:0]    w_row_sel;
    logic [COLS-1:0]         w_row_bits;
    logic                    w_active;
    logic [COLS-1:0]         w_fill [ROWS];
    logic [32:0]             w_elapsed_p1;
    logic                    w_pix_in_range;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // shared multiplier: scan uses elapsed*total, flash uses period*repeats
    assign w_mul_a = (r_mode == MODE_SCAN) ? r_elapsed[15:0] : r_flash_per;
    assign w_mul_b = (r_mode == MODE_SCAN) ? 8'(TOTAL) : r_flash_rep;
    assign w_mul_p = 24'(w_mul_a) * 24'(w_mul_b);

    // restoring divider, one quotient bit per cycle
    assign w_rem_sh   = {r_rem, r_dvd[DVD_W-1]};
    assign w_rem_diff = w_rem_sh - {1'b0, r_dvs};
    assign w_sub_ok   = (w_rem_sh >= {1'b0, r_dvs});

    assign w_elapsed_p1 = {1'b0, r_elapsed} + 33'd1;

    // pwm gate: subcycle < pct*levels/100, written without a divide
    assign w_active = (r_bright != 7'd0) &&
        (((DUTY_W'(r_sub) + DUTY_W'(1)) * DUTY_W'(100)) <=
         (DUTY_W'(r_bright) * DUTY_W'(PWM_LEVELS)));

    assign w_row_sel  = ROW_IDX_W'(r_slot - SLOT_W'(1));
    assign w_row_bits = r_pix[w_row_sel];

    assign w_pix_in_range = ({1'b0, r_row} < 5'(ROWS)) && ({1'b0, r_col} < 5'(COLS));

    // scan fill pattern: first lit pixels in row-major order
    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                w_fill[r][c] = (LIT_W'(r * COLS + c) < r_dvd[LIT_W-1:0]);
            end
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (r_cmd == CMD_TICK && r_mode != MODE_NONE) n_state = ST_PREP;
                else n_state = ST_FIN;
            end
            ST_PREP: n_state = ST_CHK;
            ST_CHK: begin
                if (r_mode == MODE_SCAN) begin
                    if ({16'd0, r_scan_dur} <= r_elapsed) n_state = ST_FIN;
                    else if ({17'd0, r_scan_dur} <= w_elapsed_p1) n_state = ST_FILL;
                    else n_state = ST_DIV;
                end else begin
                    if ({7'd0, r_prod} <= r_elapsed) n_state = ST_FIN;
                    else n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(DVD_W - 1)) n_state = ST_FILL;
            end
            ST_FILL: n_state = ST_FIN;
            ST_FIN: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_bright     <= RST_BRIGHTNESS;
            r_scan_dur   <= RST_SCAN_DUR;
            r_flash_per  <= RST_FLASH_PER;
            r_flash_rep  <= RST_FLASH_REP;
            r_special_en <= 1'b0;
            r_mode       <= MODE_NONE;
            r_elapsed    <= 32'd0;
            r_sub        <= '0;
            r_slot       <= '0;
            r_out_valid  <= 1'b0;
            for (int r = 0; r < ROWS; r++) r_pix[r] <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_BRIGHTNESS: r_bright     <= i_cfg_wdata[6:0];
                    REG_SCAN_DUR:   r_scan_dur   <= i_cfg_wdata;
                    REG_FLASH_PER:  r_flash_per  <= i_cfg_wdata;
                    REG_FLASH_REP:  r_flash_rep  <= i_cfg_wdata[7:0];
                    REG_SPECIAL_EN: r_special_en <= i_cfg_wdata[0];
                    default: ;
                endcase
            end

            // load a new result, else drop the one taken by the sink
            if (r_state == ST_FIN && w_out_free) r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;

            case (r_state)
                ST_EXEC: begin
                    case (r_cmd)
                        CMD_TICK: begin
                            if (r_mode != MODE_NONE && r_elapsed != '1)
                                r_elapsed <= r_elapsed + 32'd1;
                        end
                        CMD_START_SCAN, CMD_START_FLASH: begin
                            for (int r = 0; r < ROWS; r++) r_pix[r] <= '0;
                            r_mode    <= (r_cmd == CMD_START_SCAN) ? MODE_SCAN : MODE_FLASH;
                            r_elapsed <= 32'd0;
                        end
                        CMD_STOP: r_mode <= MODE_NONE;
                        CMD_SET_PIXEL, CMD_CLR_PIXEL: begin
                            if (r_mode == MODE_NONE && w_pix_in_range)
                                r_pix[r_row[ROW_IDX_W-1:0]][r_col[COL_IDX_W-1:0]] <=
                                    (r_cmd == CMD_SET_PIXEL);
                        end
                        CMD_CLEAR_ALL: begin
                            for (int r = 0; r < ROWS; r++) r_pix[r] <= '0;
                            r_mode <= MODE_NONE;
                        end
                        CMD_REFRESH: begin
                            // walk special slot then rows, subcycle steps on wrap
                            if (r_slot == SLOT_W'(ROWS)) begin
                                r_slot <= '0;
                                if (r_sub == SUB_W'(PWM_LEVELS - 1)) r_sub <= '0;
                                else r_sub <= r_sub + SUB_W'(1);
                            end else begin
                                r_slot <= r_slot + SLOT_W'(1);
                            end
                        end
                        default: ;
                    endcase
                end
                ST_CHK: begin
                    // effect over: clear and return to no effect
                    if ((r_mode == MODE_SCAN && {16'd0, r_scan_dur} <= r_elapsed) ||
                        (r_mode == MODE_FLASH && {7'd0, r_prod} <= r_elapsed)) begin
                        for (int r = 0; r < ROWS; r++) r_pix[r] <= '0;
                        r_mode <= MODE_NONE;
                    end
                end
                ST_FILL: begin
                    if (r_mode == MODE_SCAN) begin
                        for (int r = 0; r < ROWS; r++) r_pix[r] <= w_fill[r];
                    end else begin
                        for (int r = 0; r < ROWS; r++) r_pix[r] <= r_dvd[0] ? '0 : '1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= s_axis_tuser;
            r_row <= s_axis_tdata[3:0];
            r_col <= s_axis_tdata[7:4];
        end

        case (r_state)
            ST_EXEC: begin
                r_drv_valid <= 1'b0;
                r_drv_row   <= 4'd0;
                r_drv_cols  <= 8'd0;
                if (r_cmd == CMD_REFRESH && w_active) begin
                    if (r_slot == '0) begin
                        // special slot: last row, column 0 on its own
                        if (r_special_en && r_pix[ROWS-1][0]) begin
                            r_drv_valid <= 1'b1;
                            r_drv_row   <= 4'(ROWS - 1);
                            r_drv_cols  <= SPECIAL_MASK;
                        end
                    end else if (w_row_bits != '0) begin
                        r_drv_valid <= 1'b1;
                        r_drv_row   <= 4'(w_row_sel);
                        if (r_special_en && w_row_sel == ROW_IDX_W'(ROWS - 1))
                            r_drv_cols <= 8'(w_row_bits) & ~SPECIAL_MASK;
                        else
                            r_drv_cols <= 8'(w_row_bits);
                    end
                end
            end
            ST_PREP: begin
                if (r_mode == MODE_SCAN) r_prod <= DVD_W'(w_mul_p);
                else r_prod <= {w_mul_p, 1'b0};
            end
            ST_CHK: begin
                r_rem <= '0;
                r_cnt <= '0;
                if (r_mode == MODE_SCAN) begin
                    r_dvs <= r_scan_dur;
                    // last millisecond lights everything
                    if ({17'd0, r_scan_dur} <= w_elapsed_p1) r_dvd <= DVD_W'(TOTAL);
                    else r_dvd <= r_prod;
                end else begin
                    r_dvs <= r_flash_per;
                    r_dvd <= r_elapsed[DVD_W-1:0];
                end
            end
            ST_DIV: begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (w_sub_ok) begin
                    r_rem <= w_rem_diff[DVS_W-1:0];
                    r_dvd <= {r_dvd[DVD_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_rem_sh[DVS_W-1:0];
                    r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    r_out_data <= {2'b00, r_mode, r_drv_cols, r_drv_row};
                    r_out_user <= r_drv_valid;
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: tb/led_matrix_effect_driver_test.sv
`timescale 1ns / 1ps

module led_matrix_effect_driver_test;
    import lmed_pkg::*;

    // generous bound: every item at the slow tick path plus long gaps on both sides
    localparam int unsigned CYCLE_LIMIT = 400_000;
    localparam logic [7:0]  COL_MASK    = 8'((1 << COLS) - 1);

    // one output item as the block should present it
    typedef struct packed {
        logic       valid;
        logic [3:0] row;
        logic [7:0] cols;
        t_mode      mode;
    } t_drive;

    // matrix predictor plus the queue of drive items still owed by the block
    class t_matrix_scoreboard;
        logic [6:0]  brightness;
        logic [15:0] scan_ms;
        logic [15:0] flash_ms;
        logic [7:0]  flash_reps;
        logic        special_en;
        logic [7:0]  pixels [ROWS];
        t_mode       mode;
        logic [31:0] elapsed;
        int unsigned subcycle;
        int unsigned slot;
        t_drive      expected_drives [$];
        int unsigned mismatches;

        function new();
            brightness = RST_BRIGHTNESS;
            scan_ms    = RST_SCAN_DUR;
            flash_ms   = RST_FLASH_PER;
            flash_reps = RST_FLASH_REP;
            special_en = 1'b0;
            clear_pixels();
            mode       = MODE_NONE;
            elapsed    = '0;
            subcycle   = 0;
            slot       = 0;
            mismatches = 0;
        endfunction

        function void clear_pixels();
            foreach (pixels[r]) pixels[r] = '0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [15:0] value);
            case (idx)
                REG_BRIGHTNESS: brightness = value[6:0];
                REG_SCAN_DUR:   scan_ms    = value;
                REG_FLASH_PER:  flash_ms   = value;
                REG_FLASH_REP:  flash_reps = value[7:0];
                REG_SPECIAL_EN: special_en = value[0];
                default: ;
            endcase
        endfunction

        // scan fill: first elapsed*total/duration pixels lit, row-major; all lit in the last ms, cleared after
        function void advance_scan();
            logic [63:0] product;
            int unsigned lit;
            int unsigned k;
            if (elapsed >= scan_ms) begin
                clear_pixels();
                mode = MODE_NONE;
                return;
            end
            if (elapsed + 1 >= scan_ms) begin
                lit = TOTAL;
            end else begin
                product = 64'(elapsed) * 64'(TOTAL);
                lit     = int'(product / scan_ms);
            end
            clear_pixels();
            for (k = 0; k < lit; k++) pixels[k / COLS][k % COLS] = 1'b1;
        endfunction

        // flash: all on in even periods, all off in odd ones, cleared once the flash span is over
        function void advance_flash();
            logic [31:0] span;
            span = 32'(flash_reps) * 32'd2 * 32'(flash_ms);
            if (elapsed >= span) begin
                mode = MODE_NONE;
                clear_pixels();
            end else if (((elapsed / flash_ms) & 32'd1) == 32'd0) begin
                foreach (pixels[r]) pixels[r] = COL_MASK;
            end else begin
                clear_pixels();
            end
        endfunction

        // one refresh slot: special slot first, then one slot per row
        function t_drive next_slot();
            t_drive      d;
            int unsigned duty;
            logic [7:0]  bits;
            d    = '0;
            duty = (32'(brightness) * PWM_LEVELS) / 100;
            if (brightness != 0 && subcycle < duty) begin
                if (slot == 0) begin
                    if (special_en && pixels[ROWS-1][0]) begin
                        d.valid = 1'b1;
                        d.row   = 4'(ROWS - 1);
                        d.cols  = SPECIAL_MASK;
                    end
                end else if (slot <= ROWS) begin
                    bits = pixels[slot-1] & COL_MASK;
                    if (bits != 0) begin
                        if (special_en && slot == ROWS) bits = bits & ~SPECIAL_MASK;
                        d.valid = 1'b1;
                        d.row   = 4'(slot - 1);
                        d.cols  = bits;
                    end
                end
            end
            slot++;
            if (slot > ROWS) begin
                slot = 0;
                subcycle++;
                if (subcycle >= PWM_LEVELS) subcycle = 0;
            end
            return d;
        endfunction

        function void accept_command(t_cmd cmd, logic [3:0] row, logic [3:0] col);
            t_drive d;
            d = '0;
            case (cmd)
                CMD_TICK: begin
                    if (mode != MODE_NONE) begin
                        if (elapsed != '1) elapsed++;
                        if (mode == MODE_SCAN) advance_scan();
                        else advance_flash();
                    end
                end
                CMD_START_SCAN, CMD_START_FLASH: begin
                    clear_pixels();
                    mode    = (cmd == CMD_START_SCAN) ? MODE_SCAN : MODE_FLASH;
                    elapsed = '0;
                end
                CMD_STOP: mode = MODE_NONE;
                CMD_SET_PIXEL, CMD_CLR_PIXEL: begin
                    if (mode == MODE_NONE && row < ROWS && col < COLS)
                        pixels[row][col] = (cmd == CMD_SET_PIXEL);
                end
                CMD_CLEAR_ALL: begin
                    clear_pixels();
                    mode = MODE_NONE;
                end
                default: d = next_slot();
            endcase
            d.mode = mode;
            expected_drives.push_back(d);
        endfunction

        function void check_drive(logic valid, logic [3:0] row, logic [7:0] cols,
                                  logic [1:0] mode_bits);
            t_drive want;
            if (expected_drives.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output item: valid=%0d row=%0d cols=%02h mode=%0d",
                             valid, row, cols, mode_bits);
                return;
            end
            want = expected_drives.pop_front();
            if (want.valid !== valid || want.row !== row || want.cols !== cols ||
                2'(want.mode) !== mode_bits) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("drive mismatch: expected valid=%0d row=%0d cols=%02h mode=%0d",
                             want.valid, want.row, want.cols, 2'(want.mode));
                    $display("                got      valid=%0d row=%0d cols=%02h mode=%0d",
                             valid, row, cols, mode_bits);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_drives.size();
        endfunction
    endclass

    // all block inputs start at known values, reset held low from time zero
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [3:0] pixel_row, [7:4] pixel_col
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // [2:0] command
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [3:0] out_row, [11:4] drive_cols, [13:12] effect_mode, [15:14] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // [0] drive_valid
    logic                  m_axis_tuser;

    t_matrix_scoreboard board;
    int unsigned      items_sent    = 0;
    int unsigned      cycle_count   = 0;
    bit               steady_source = 1'b0;
    bit               steady_sink   = 1'b0;
    int unsigned      stall_left    = 0;
    int unsigned      stretch_left  = 0;

    led_matrix_effect_driver u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // idle length: mostly short, now and then a long one
    function automatic int unsigned pick_gap();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    // row or column mostly inside the matrix, sometimes anywhere in the field
    function automatic logic [3:0] pick_coord(int unsigned limit);
        return ($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(0, limit - 1));
    endfunction

    function automatic logic [3:0] any_nibble();
        return 4'($urandom_range(0, 15));
    endfunction

    // output side: check on handshake, then pick tready for the next cycle
    // each stretch picks random stalls or, one time in four, a sink that never stalls
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_drive(m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[11:4],
                              m_axis_tdata[13:12]);
        if (stretch_left == 0) begin
            stretch_left <= $urandom_range(20, 200);
            steady_sink  <= ($urandom_range(0, 3) == 0);
        end else begin
            stretch_left <= stretch_left - 1;
        end
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (!steady_sink && $urandom_range(0, 99) < 30) begin
            m_axis_tready <= 1'b0;
            stall_left    <= pick_gap() - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // present one item, hold it until accepted, then hand it to the predictor
    // tvalid is only dropped for a gap or a drain, so back-to-back items keep it high
    task automatic send(input t_cmd cmd, input logic [3:0] row, input logic [3:0] col);
        int unsigned gap;
        gap = (steady_source || $urandom_range(0, 99) < 60) ? 0 : pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {col, row};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        board.accept_command(cmd, row, col);
        items_sent++;
    endtask

    // hold off input until every owed output item has come and the block is idle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0 || !s_axis_tready);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        board.write_reg(idx, value);
    endtask

    // only called with the block drained
    task automatic configure(input logic [6:0] pct, input logic [15:0] scan_len,
                             input logic [15:0] flash_len, input logic [7:0] reps,
                             input logic special);
        write_reg(REG_BRIGHTNESS, 16'(pct));
        write_reg(REG_SCAN_DUR, scan_len);
        write_reg(REG_FLASH_PER, flash_len);
        write_reg(REG_FLASH_REP, 16'(reps));
        write_reg(REG_SPECIAL_EN, 16'(special));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // start an effect and tick it toward or past its end, with refreshes, stops and pixel edits sprinkled in
    // pixel edits that land while the effect runs must be ignored
    task automatic play_effect();
        t_cmd        start_cmd;
        int unsigned span;
        int unsigned i;
        int unsigned pick;
        start_cmd = ($urandom_range(0, 1) == 0) ? CMD_START_SCAN : CMD_START_FLASH;
        if (start_cmd == CMD_START_SCAN) span = board.scan_ms;
        else span = 32'(board.flash_reps) * 2 * 32'(board.flash_ms);
        if (span > 40) span = 40;
        send(start_cmd, any_nibble(), any_nibble());
        for (i = 0; i < span + 2; i++) begin
            pick = $urandom_range(0, 79);
            if (pick == 0)
                send(CMD_STOP, any_nibble(), any_nibble());
            else if (pick <= 3)
                send((pick == 1) ? CMD_CLR_PIXEL : CMD_SET_PIXEL, pick_coord(ROWS),
                     pick_coord(COLS));
            else if (pick <= 15)
                send(CMD_REFRESH, any_nibble(), any_nibble());
            else
                send(CMD_TICK, any_nibble(), any_nibble());
        end
    endtask

    // edit the bitmap and then sweep the refresh slots over it
    task automatic draw_and_sweep();
        int unsigned edits;
        int unsigned sweeps;
        int unsigned i;
        if (board.mode != MODE_NONE && $urandom_range(0, 3) != 0)
            send(CMD_STOP, any_nibble(), any_nibble());
        if ($urandom_range(0, 2) == 0) send(CMD_CLEAR_ALL, any_nibble(), any_nibble());
        // the pixel that owns the special slot
        if ($urandom_range(0, 2) == 0) send(CMD_SET_PIXEL, 4'(ROWS - 1), 4'd0);
        edits = $urandom_range(2, 10);
        for (i = 0; i < edits; i++)
            send(($urandom_range(0, 3) != 0) ? CMD_SET_PIXEL : CMD_CLR_PIXEL,
                 pick_coord(ROWS), pick_coord(COLS));
        sweeps = $urandom_range(ROWS + 1, 3 * (ROWS + 1));
        for (i = 0; i < sweeps; i++) send(CMD_REFRESH, any_nibble(), any_nibble());
    endtask

    task automatic send_noise();
        int unsigned n;
        int unsigned i;
        n = $urandom_range(3, 8);
        for (i = 0; i < n; i++) send(t_cmd'($urandom_range(0, 7)), any_nibble(), any_nibble());
    endtask

    task automatic run_phase(input int unsigned quota);
        int unsigned first_item;
        int unsigned kind;
        steady_source = ($urandom_range(0, 3) == 0);
        first_item    = items_sent;
        while (items_sent - first_item < quota) begin
            kind = $urandom_range(0, 9);
            if (kind <= 3) begin
                play_effect();
            end else if (kind <= 6) begin
                draw_and_sweep();
            end else if (kind == 7) begin
                send_noise();
            end else begin
                // with kind 9 the sender holds back until the block has caught up
                if (kind == 9) wait_drained();
                send_noise();
            end
        end
    endtask

    initial begin
        board = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at reset settings
        send(CMD_SET_PIXEL, 4'(ROWS - 1), 4'd0);
        send(CMD_SET_PIXEL, 4'd0, 4'(COLS - 1));
        send(CMD_SET_PIXEL, 4'hF, 4'hF);          // both out of range
        send(CMD_SET_PIXEL, 4'd3, 4'(COLS));      // column just past the edge
        send(CMD_SET_PIXEL, 4'(ROWS), 4'd3);      // row just past the edge
        send(CMD_CLR_PIXEL, 4'd0, 4'(COLS - 1));
        send(CMD_SET_PIXEL, 4'd0, 4'd0);
        repeat (ROWS + 1) send(CMD_REFRESH, 4'hF, 4'h0);   // one full slot walk
        send(CMD_START_SCAN, 4'h0, 4'hF);
        send(CMD_SET_PIXEL, 4'd2, 4'd2);          // ignored while scanning
        send(CMD_TICK, 4'h5, 4'hA);
        send(CMD_STOP, 4'hA, 4'h5);               // bitmap kept
        send(CMD_TICK, 4'h0, 4'h0);               // no effect, nothing moves
        send(CMD_SET_PIXEL, 4'd2, 4'd2);
        send(CMD_START_FLASH, 4'hF, 4'hF);
        send(CMD_TICK, 4'h0, 4'h0);
        send(CMD_CLEAR_ALL, 4'h0, 4'h0);
        send(CMD_REFRESH, 4'h0, 4'h0);
        wait_drained();

        // random part over a range of settings, extremes included
        configure(7'd100, 16'd5, 16'd2, 8'd2, 1'b1);
        run_phase(40);
        wait_drained();
        configure(7'd0, 16'd1, 16'd1, 8'd1, 1'b0);          // drive disabled
        run_phase(40);
        wait_drained();
        configure(7'd127, 16'd64, 16'd3, 8'd3, 1'b1);       // above full brightness
        run_phase(40);
        wait_drained();
        configure(7'd4, 16'd0, 16'd0, 8'd0, 1'b1);          // zero lengths, zero duty
        run_phase(40);
        wait_drained();
        configure(7'd55, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);  // effects that outlast the run
        run_phase(40);
        wait_drained();
        configure(7'd5, 16'd17, 16'd1, 8'd4, 1'b1);         // single active subcycle
        run_phase(40);
        wait_drained();
        configure(7'd95, 16'd3, 16'd5, 8'd1, 1'b1);
        run_phase(40);
        wait_drained();
        configure(7'($urandom_range(0, 127)), 16'($urandom_range(1, 40)),
                  16'($urandom_range(1, 6)), 8'($urandom_range(0, 4)),
                  1'($urandom_range(0, 1)));
        run_phase(40);
        wait_drained();
        configure(7'd100, 16'd200, 16'd7, 8'd2, 1'b0);
        run_phase(40);

        // drain, then give a stray extra item time to show up
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
